/* rtl/core/trpa_pkg.sv */
// ----------------------------------------------------------------------------
// trpa_pkg
// Shared constants, codes and helpers of the two-region page allocator.
// ----------------------------------------------------------------------------
package trpa_pkg;

    localparam int KRNL_PAGE_CNT_DEF  = 1024;
    localparam int USER_PAGES_MAX_DEF = 32768;
    localparam int PAGE_BITS_DEF      = 12;

    localparam int ADDR_W    = 34;
    localparam int BASE_W    = 22;
    localparam int COUNT_W   = 16;
    localparam int FIRST_W   = 24;
    localparam int PB_MAX    = 16;
    localparam int DATA_W    = 32;
    localparam int PADDR_W   = 3;

    localparam logic [BASE_W-1:0] BASE_PAGE_RST  = 22'd524288;
    localparam int                USER_PAGES_RST = 32768;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    localparam logic REG_BASE_PAGE  = 1'b0;
    localparam logic REG_USER_PAGES = 1'b1;

    function automatic int idx_w(input int n);
        idx_w = (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

/* rtl/core/trpa_ram.sv */
// ----------------------------------------------------------------------------
// trpa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module trpa_ram
    import trpa_pkg::*;
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
)
(
    input  logic                    clk,
    input  logic                    we,
    input  logic [idx_w(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]        wdata,
    input  logic [idx_w(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/two_region_page_allocator.sv */
// ----------------------------------------------------------------------------
// two_region_page_allocator
// Page frame allocator with a kernel and a user region, each with a free
// stack in RAM plus a counter of pages never handed out.
// Result: shown (done) in the cycle right after acceptance. Busy holds
// off a new item while a result shows; the stack RAM read is registered.
// The receiver cannot stall.
// Reset: fill counts clear, fresh counters load region sizes; stack RAM
// contents stay undefined and need no clearing pass.
// ----------------------------------------------------------------------------
module two_region_page_allocator
    import trpa_pkg::*;
#(
    parameter int KRNL_PAGE_CNT  = KRNL_PAGE_CNT_DEF,
    parameter int USER_PAGES_MAX = USER_PAGES_MAX_DEF,
    parameter int PAGE_BITS      = PAGE_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               func,
    input  logic               kernel_sel,
    input  logic [ADDR_W-1:0]  page_addr,
    output logic               done,
    output logic [ADDR_W-1:0]  alloc_addr,
    output logic [1:0]         status,
    output logic [COUNT_W-1:0] free_count,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    localparam int KIW = idx_w(KRNL_PAGE_CNT);
    localparam int KCW = $clog2(KRNL_PAGE_CNT + 1);
    localparam int UIW = idx_w(USER_PAGES_MAX);
    localparam int UCW = $clog2(USER_PAGES_MAX + 1);
    localparam int USER_RST = (USER_PAGES_RST > USER_PAGES_MAX) ?
                              USER_PAGES_MAX : USER_PAGES_RST;

    logic [BASE_W-1:0]  base_page_reg,  base_page_next;
    logic [COUNT_W-1:0] user_pages_reg, user_pages_next;
    logic [KCW-1:0]     kern_top_reg,   kern_top_next;
    logic [KCW-1:0]     kern_fresh_reg, kern_fresh_next;
    logic [UCW-1:0]     user_top_reg,   user_top_next;
    logic [UCW-1:0]     user_fresh_reg, user_fresh_next;

    logic               rsp_valid_reg,  rsp_valid_next;
    logic               rsp_kern_reg,   rsp_kern_next;
    logic               rsp_pop_reg,    rsp_pop_next;
    logic               rsp_got_reg,    rsp_got_next;
    logic [FIRST_W-1:0] rsp_first_reg,  rsp_first_next;
    logic [FIRST_W-1:0] rsp_idx_reg,    rsp_idx_next;
    logic [1:0]         rsp_status_reg, rsp_status_next;
    logic [COUNT_W-1:0] rsp_count_reg,  rsp_count_next;

    logic               accept;
    logic               cfg_wr;
    logic [31:0]        cfg_user;
    logic [31:0]        top_w, fresh_w, size_w, depth_w;
    logic [31:0]        new_top, new_fresh;
    logic [FIRST_W-1:0] first_w;
    logic [ADDR_W-1:0]  pg_full;
    logic [ADDR_W-1:0]  pg_lo, pg_hi;
    logic               misaligned;
    logic               do_push;
    logic [ADDR_W-1:0]  push_rel;

    logic               kern_we, user_we;
    logic [KIW-1:0]     kern_waddr, kern_raddr;
    logic [UIW-1:0]     user_waddr, user_raddr;
    logic [KIW-1:0]     kern_rdata;
    logic [UIW-1:0]     user_rdata;

    logic [FIRST_W-1:0]        out_idx;
    logic [FIRST_W-1:0]        out_pg;
    logic [FIRST_W+PB_MAX-1:0] out_wide;

    assign accept = start && !busy;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign busy   = rsp_valid_reg;
    assign done   = rsp_valid_reg;

    assign prdata = (paddr[2] == REG_USER_PAGES) ? DATA_W'(user_pages_reg)
                                                 : DATA_W'(base_page_reg);

    assign cfg_user = (32'(pwdata[COUNT_W-1:0]) > 32'(USER_PAGES_MAX)) ?
                      32'(USER_PAGES_MAX) : 32'(pwdata[COUNT_W-1:0]);

    always_comb
    begin
        top_w      = kernel_sel ? 32'(kern_top_reg)   : 32'(user_top_reg);
        fresh_w    = kernel_sel ? 32'(kern_fresh_reg) : 32'(user_fresh_reg);
        size_w     = kernel_sel ? 32'(KRNL_PAGE_CNT)  : 32'(user_pages_reg);
        depth_w    = kernel_sel ? 32'(KRNL_PAGE_CNT)  : 32'(USER_PAGES_MAX);
        first_w    = kernel_sel ? FIRST_W'(base_page_reg)
                                : FIRST_W'(base_page_reg) + FIRST_W'(KRNL_PAGE_CNT);
        pg_full    = page_addr >> PAGE_BITS;
        pg_lo      = ADDR_W'(first_w);
        pg_hi      = ADDR_W'(first_w) + ADDR_W'(size_w);
        misaligned = (page_addr & ((ADDR_W'(1) << PAGE_BITS) - ADDR_W'(1))) != '0;
        push_rel   = pg_full - pg_lo;

        new_top         = top_w;
        new_fresh       = fresh_w;
        do_push         = 1'b0;
        rsp_pop_next    = 1'b0;
        rsp_got_next    = 1'b0;
        rsp_idx_next    = '0;
        rsp_status_next = ST_OK;

        if (func == FN_ALLOC)
        begin
            if (top_w > 32'd0 && top_w <= depth_w)
            begin
                new_top      = top_w - 32'd1;
                rsp_pop_next = 1'b1;
                rsp_got_next = 1'b1;
            end
            else if (fresh_w > 32'd0)
            begin
                new_fresh    = fresh_w - 32'd1;
                rsp_idx_next = FIRST_W'(new_fresh);
                rsp_got_next = 1'b1;
            end
            else
            begin
                rsp_status_next = ST_EMPTY;
            end
        end
        else
        begin
            if (misaligned || pg_full < pg_lo || pg_full >= pg_hi)
            begin
                rsp_status_next = ST_RANGE;
            end
            else if (top_w + fresh_w >= size_w || top_w >= depth_w)
            begin
                rsp_status_next = ST_OVERFLOW;
            end
            else
            begin
                do_push = 1'b1;
                new_top = top_w + 32'd1;
            end
        end

        rsp_valid_next = accept;
        rsp_kern_next  = kernel_sel;
        rsp_first_next = first_w;
        rsp_count_next = COUNT_W'(new_top + new_fresh);
    end

    always_comb
    begin
        kern_we    = accept && do_push && kernel_sel;
        user_we    = accept && do_push && !kernel_sel;
        kern_waddr = kern_top_reg[KIW-1:0];
        user_waddr = user_top_reg[UIW-1:0];
        kern_raddr = KIW'(kern_top_reg - KCW'(1));
        user_raddr = UIW'(user_top_reg - UCW'(1));
    end

    always_comb
    begin
        base_page_next  = base_page_reg;
        user_pages_next = user_pages_reg;
        kern_top_next   = kern_top_reg;
        kern_fresh_next = kern_fresh_reg;
        user_top_next   = user_top_reg;
        user_fresh_next = user_fresh_reg;
        if (accept)
        begin
            if (kernel_sel)
            begin
                kern_top_next   = KCW'(new_top);
                kern_fresh_next = KCW'(new_fresh);
            end
            else
            begin
                user_top_next   = UCW'(new_top);
                user_fresh_next = UCW'(new_fresh);
            end
        end
        if (cfg_wr)
        begin
            if (paddr[2] == REG_BASE_PAGE)
            begin
                base_page_next = pwdata[BASE_W-1:0];
            end
            else
            begin
                user_pages_next = COUNT_W'(cfg_user);
                user_fresh_next = UCW'(cfg_user);
                user_top_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_page_reg  <= BASE_PAGE_RST;
            user_pages_reg <= COUNT_W'(USER_RST);
            kern_top_reg   <= '0;
            kern_fresh_reg <= KCW'(KRNL_PAGE_CNT);
            user_top_reg   <= '0;
            user_fresh_reg <= UCW'(USER_RST);
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            base_page_reg  <= base_page_next;
            user_pages_reg <= user_pages_next;
            kern_top_reg   <= kern_top_next;
            kern_fresh_reg <= kern_fresh_next;
            user_top_reg   <= user_top_next;
            user_fresh_reg <= user_fresh_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_kern_reg   <= rsp_kern_next;
            rsp_pop_reg    <= rsp_pop_next;
            rsp_got_reg    <= rsp_got_next;
            rsp_first_reg  <= rsp_first_next;
            rsp_idx_reg    <= rsp_idx_next;
            rsp_status_reg <= rsp_status_next;
            rsp_count_reg  <= rsp_count_next;
        end
    end

    trpa_ram #(
        .WIDTH (KIW),
        .DEPTH (KRNL_PAGE_CNT)
    ) u_kern_stack (
        .clk   (clk),
        .we    (kern_we),
        .waddr (kern_waddr),
        .wdata (push_rel[KIW-1:0]),
        .raddr (kern_raddr),
        .rdata (kern_rdata)
    );

    trpa_ram #(
        .WIDTH (UIW),
        .DEPTH (USER_PAGES_MAX)
    ) u_user_stack (
        .clk   (clk),
        .we    (user_we),
        .waddr (user_waddr),
        .wdata (push_rel[UIW-1:0]),
        .raddr (user_raddr),
        .rdata (user_rdata)
    );

    always_comb
    begin
        if (rsp_pop_reg)
        begin
            out_idx = rsp_kern_reg ? FIRST_W'(kern_rdata) : FIRST_W'(user_rdata);
        end
        else
        begin
            out_idx = rsp_idx_reg;
        end
        out_pg     = rsp_first_reg + out_idx;
        out_wide   = (FIRST_W+PB_MAX)'(out_pg) << PAGE_BITS;
        alloc_addr = rsp_got_reg ? out_wide[ADDR_W-1:0] : '0;
        status     = rsp_status_reg;
        free_count = rsp_count_reg;
    end

    a_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("accepted item gave no result");

    a_kern_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(kern_top_reg) + 32'(kern_fresh_reg)) <= 32'(KRNL_PAGE_CNT))
        else $error("kernel free count exceeds region size");

    a_user_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(user_top_reg) + 32'(user_fresh_reg)) <= 32'(user_pages_reg))
        else $error("user free count exceeds region size");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (alloc_addr == '0))
        else $error("failed request returned an address");

endmodule
